@@ rtl/core/ocg_pkg.sv @@
// Package for the occupancy grid ray update block: payload types, register indexes,
// angle constants and the CORDIC arctangent table. No dependencies.
`default_nettype none
package ocg_pkg;

	// Default sizes of the grid and the march.
	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;
	localparam int CELL_SHIFT_DEF  = 4;
	localparam int MAX_STEPS_DEF   = 63;

	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_HALF_WIDTH = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_INC       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCC_INC        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRIOR_INC      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 4'd7;

	// Angles in Q10.6 degrees.
	localparam int DEG360 = 23040;
	localparam int DEG180 = 11520;
	localparam int DEG90  = 5760;

	// CORDIC datapath.
	localparam int COS_W  = 18;
	localparam int CXY_W  = 20;
	localparam int CZ_W   = 25;
	localparam int CORDIC_ITER = 16;
	localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 20'sd39797;

	// Square root argument and root widths.
	localparam int SQ_ARG_W  = 30;
	localparam int SQ_ROOT_W = 16;

	// One beam.
	typedef struct packed {
		logic signed [15:0] robot_x;
		logic signed [15:0] robot_y;
		logic signed [15:0] robot_heading;
		logic signed [15:0] beam_angle;
		logic [14:0]        measured_range;
	} beam_t;

	// One updated cell.
	typedef struct packed {
		logic [5:0]         cell_x;
		logic [5:0]         cell_y;
		logic signed [15:0] cell_value;
		logic               last;
	} cell_upd_t;

	// Arctangent of 2^-i in Q.16 degrees.
	function automatic logic signed [CZ_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [CZ_W-1:0] a;
		case (i)
			4'd0:    a = 25'sd2949120;
			4'd1:    a = 25'sd1740967;
			4'd2:    a = 25'sd919879;
			4'd3:    a = 25'sd466945;
			4'd4:    a = 25'sd234379;
			4'd5:    a = 25'sd117304;
			4'd6:    a = 25'sd58666;
			4'd7:    a = 25'sd29335;
			4'd8:    a = 25'sd14668;
			4'd9:    a = 25'sd7334;
			4'd10:   a = 25'sd3667;
			4'd11:   a = 25'sd1834;
			4'd12:   a = 25'sd917;
			4'd13:   a = 25'sd458;
			4'd14:   a = 25'sd229;
			default: a = 25'sd115;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/ocg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ocg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/ocg_cordic.sv @@
// Iterative CORDIC cosine, one micro-rotation per cycle.
// Depends on ocg_pkg for widths, gain and the arctangent table.
`default_nettype none
module ocg_cordic import ocg_pkg::*; (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire signed [CZ_W-1:0]       angle,
	output logic                        done,
	output logic signed [COS_W-1:0]     cos_val
);

	logic signed [CXY_W-1:0] x_q, y_q, xs, ys;
	logic signed [CZ_W-1:0]  z_q;
	logic [3:0]              i_q;
	logic                    run_q, done_q;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	// Control: iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_ITER - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Rotation datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= angle;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(i_q);
			end
		end
	end

	// Clamp the result to plus or minus one in Q16.
	always_comb begin
		if (x_q > 20'sd65536) begin
			cos_val = 18'sd65536;
		end else if (x_q < -20'sd65536) begin
			cos_val = -18'sd65536;
		end else begin
			cos_val = COS_W'(x_q);
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/core/ocg_isqrt.sv @@
// Iterative integer square root rounded to nearest, one result bit per cycle.
// Depends on ocg_pkg for the argument and root widths.
`default_nettype none
module ocg_isqrt import ocg_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [SQ_ARG_W-1:0]       arg,
	output logic                     done,
	output logic [SQ_ROOT_W-1:0]     root
);

	logic [SQ_ARG_W-1:0] v_q;
	logic [SQ_ARG_W:0]   r_q, sum;
	logic [SQ_ARG_W-2:0] bit_q;
	logic                run_q, done_q;

	assign sum = r_q + (SQ_ARG_W + 1)'(bit_q);

	// Control: run while the trial bit has not passed bit zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Digit-by-digit restoring square root.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= arg;
			r_q   <= '0;
			bit_q <= {1'b1, {(SQ_ARG_W - 2){1'b0}}};
		end else if (run_q) begin
			if ((SQ_ARG_W + 1)'(v_q) >= sum) begin
				v_q <= v_q - SQ_ARG_W'(sum);
				r_q <= (r_q >> 1) + (SQ_ARG_W + 1)'(bit_q);
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Round up when the remainder exceeds the root.
	assign root = ((SQ_ARG_W + 1)'(v_q) > r_q) ? SQ_ROOT_W'(r_q + 1'b1) : SQ_ROOT_W'(r_q);
	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/core/occupancy_grid_ray_update_top.sv @@
// Occupancy grid ray update: top level with the beam sequencer, shared multiplier and grid.
// Depends on ocg_pkg, ocg_ram, ocg_cordic and ocg_isqrt.
//
// Each accepted beam (start high while busy is low) updates the robot's cell and then up to
// MAX_STEPS cells along the beam, each as a read-modify-write of the log-odds grid, and emits
// one result per written cell with last set on the final one. A result is on the result port
// for exactly one cycle, flagged by result_valid; the receiver cannot stall it. After reset the
// block sweeps all GRID_WIDTH*GRID_HEIGHT cells (4096 by default) to zero, one cell a cycle,
// with busy high. A beam keeps busy high through its setup: angle reduction, the 16 CORDIC
// iterations, the multiplier states S_M0 to S_M3, the 15 square root iterations, and the band
// squares and the robot cell. The robot cell is then read and written (S_RD, S_WR), and each
// march step runs through S_STEP, S_CELL, S_EX, S_EY, S_R2, S_RD and S_WR using the single
// shared multiplier and the grid RAM port. A beam is taken only while busy is low, so a new
// beam cannot be accepted before the last one is through. The last result appears in the same
// cycle as busy falls. Configuration beats are always accepted and must only be written while
// busy is low.
`default_nettype none
module occupancy_grid_ray_update_top import ocg_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int CELL_SHIFT  = CELL_SHIFT_DEF,
	parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire beam_t           beam,
	output logic                 result_valid,
	output cell_upd_t            result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [15:0]           cfg_data
);

	localparam int CW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int RW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMAXW = (CW > RW) ? CW : RW;
	localparam int MW    = ((CMAXW + CELL_SHIFT + 2 > 18) ? CMAXW + CELL_SHIFT + 2 : 18) + 2;
	localparam int PW    = 24;
	localparam int DW    = 25;
	localparam int LW    = 22;

	// Sequencer states.
	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RED   = 5'd2;
	localparam logic [4:0] S_COR   = 5'd3;
	localparam logic [4:0] S_M0    = 5'd4;
	localparam logic [4:0] S_M1    = 5'd5;
	localparam logic [4:0] S_M2    = 5'd6;
	localparam logic [4:0] S_M3    = 5'd7;
	localparam logic [4:0] S_SQ    = 5'd8;
	localparam logic [4:0] S_LO    = 5'd9;
	localparam logic [4:0] S_HI    = 5'd10;
	localparam logic [4:0] S_ROBOT = 5'd11;
	localparam logic [4:0] S_RD    = 5'd12;
	localparam logic [4:0] S_WR    = 5'd13;
	localparam logic [4:0] S_STEP  = 5'd14;
	localparam logic [4:0] S_CELL  = 5'd15;
	localparam logic [4:0] S_EX    = 5'd16;
	localparam logic [4:0] S_EY    = 5'd17;
	localparam logic [4:0] S_R2    = 5'd18;

	// Cell index of an offset from the origin: ceiling division, clamped to the grid.
	function automatic logic [9:0] cell_of(input logic signed [DW-1:0] d, input int size);
		logic signed [DW-1:0] q;
		logic [9:0]           c;
		q = (d + $signed(DW'((1 << CELL_SHIFT) - 1))) >>> CELL_SHIFT;
		if (q < $signed(DW'(1))) begin
			c = '0;
		end else if (q > $signed(DW'(size - 1))) begin
			c = 10'(size - 1);
		end else begin
			c = 10'(q);
		end
		return c;
	endfunction

	// Configuration registers.
	logic [14:0]        step_q, max_range_q, half_q;
	logic signed [15:0] free_q, occ_q, prior_q, origin_x_q, origin_y_q;

	// Sequencer and datapath registers.
	logic [4:0]              state_q;
	logic [AW-1:0]           clr_q;
	beam_t                   beam_q;
	logic signed [17:0]      t_q;
	logic                    neg_q;
	logic signed [COS_W-1:0] c_q;
	logic signed [16:0]      dx_q, dy_q;
	logic signed [2*MW-1:0]  mul_q, acc_q, lo2_q, hi2_q;
	logic signed [17:0]      lo_q;
	logic signed [PW-1:0]    px_q, py_q;
	logic [CW-1:0]           cx_q;
	logic [RW-1:0]           cy_q;
	logic                    same_q;
	logic signed [16:0]      inc_q;
	logic [LW-1:0]           length_q;
	logic [5:0]              steps_q;
	logic                    res_valid_q;
	cell_upd_t               res_q;

	// Combinational helpers.
	logic signed [MW-1:0]    mul_a, mul_b, ex, ey, lo_c, hi_c;
	logic signed [2*MW:0]    r2;
	logic signed [17:0]      z1, z2;
	logic                    fold;
	logic                    cor_start, cor_done, sq_start, sq_done;
	logic signed [COS_W-1:0] cos_val;
	logic [SQ_ROOT_W-1:0]    root;
	logic [AW-1:0]           addr, waddr;
	logic                    we;
	logic [15:0]             rdata, wdata;
	logic signed [17:0]      sum;
	logic signed [15:0]      sat_val;
	logic signed [DW-1:0]    dxo, dyo;
	logic [9:0]              ncx, ncy;
	logic                    more;
	logic signed [16:0]      inc_c;

	// Configuration writes; unknown indexes are dropped.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 15'd26;
			max_range_q <= 15'd1280;
			half_q      <= 15'd26;
			free_q      <= -16'sd156;
			occ_q       <= 16'sd156;
			prior_q     <= 16'sd0;
			origin_x_q  <= -16'sd1280;
			origin_y_q  <= -16'sd1280;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_LENGTH:    step_q      <= cfg_data[14:0];
				REG_MAX_RANGE:      max_range_q <= cfg_data[14:0];
				REG_HIT_HALF_WIDTH: half_q      <= cfg_data[14:0];
				REG_FREE_INC:       free_q      <= $signed(cfg_data);
				REG_OCC_INC:        occ_q       <= $signed(cfg_data);
				REG_PRIOR_INC:      prior_q     <= $signed(cfg_data);
				REG_ORIGIN_X:       origin_x_q  <= $signed(cfg_data);
				REG_ORIGIN_Y:       origin_y_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Angle folding into [-90, 90] degrees with a sign flag.
	always_comb begin
		z1 = (t_q > 18'sd11520) ? t_q - 18'(DEG360) : t_q;
		fold = 1'b0;
		z2 = z1;
		if (z1 > 18'(DEG90)) begin
			z2 = z1 - 18'(DEG180);
			fold = 1'b1;
		end else if (z1 < -18'(DEG90)) begin
			z2 = z1 + 18'(DEG180);
			fold = 1'b1;
		end
	end

	assign cor_start = (state_q == S_RED) && (t_q >= 0) && (t_q < 18'(DEG360));
	assign sq_start  = (state_q == S_M3);

	ocg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (CZ_W'(z2) <<< 10),
		.done    (cor_done),
		.cos_val (cos_val)
	);

	ocg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.arg    (SQ_ARG_W'(acc_q - mul_q)),
		.done   (sq_done),
		.root   (root)
	);

	// Distance terms, doubled so that the cell centre stays an integer.
	assign ex = (MW'(origin_x_q) <<< 1) + $signed(MW'({cx_q, 1'b1}) << CELL_SHIFT)
		- (MW'(beam_q.robot_x) <<< 1);
	assign ey = (MW'(origin_y_q) <<< 1) + $signed(MW'({cy_q, 1'b1}) << CELL_SHIFT)
		- (MW'(beam_q.robot_y) <<< 1);
	assign lo_c = MW'(($signed({3'b0, beam_q.measured_range}) - $signed({3'b0, half_q})) <<< 1);
	assign hi_c = MW'(($signed({3'b0, beam_q.measured_range}) + $signed({3'b0, half_q})) <<< 1);

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = MW'($signed({1'b0, step_q}));
		mul_b = MW'($signed({1'b0, step_q}));
		case (state_q)
			S_M0: mul_b = MW'(c_q);
			S_M2: begin
				mul_a = MW'(dx_q);
				mul_b = MW'(dx_q);
			end
			S_LO: begin
				mul_a = lo_c;
				mul_b = lo_c;
			end
			S_HI: begin
				mul_a = hi_c;
				mul_b = hi_c;
			end
			S_EX: begin
				mul_a = ex;
				mul_b = ex;
			end
			S_EY: begin
				mul_a = ey;
				mul_b = ey;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Cell lookup for the robot (in S_ROBOT) and for the march position (in S_CELL).
	always_comb begin
		if (state_q == S_ROBOT) begin
			dxo = DW'(beam_q.robot_x) - DW'(origin_x_q);
			dyo = DW'(beam_q.robot_y) - DW'(origin_y_q);
		end else begin
			dxo = DW'(px_q) - DW'(origin_x_q);
			dyo = DW'(py_q) - DW'(origin_y_q);
		end
		ncx = cell_of(dxo, GRID_WIDTH);
		ncy = cell_of(dyo, GRID_HEIGHT);
	end

	// Increment choice from the squared distance against the occupied band.
	always_comb begin
		r2 = (2*MW+1)'(acc_q) + (2*MW+1)'(mul_q);
		inc_c = '0;
		if (lo_q > 0 && r2 < (2*MW+1)'(lo2_q)) begin
			inc_c = 17'(free_q);
		end
		if (lo_q < 0 || r2 > (2*MW+1)'(lo2_q)) begin
			inc_c = 17'(occ_q);
		end
		if (r2 > (2*MW+1)'(hi2_q) || same_q) begin
			inc_c = '0;
		end
	end

	// Grid access and saturating update.
	assign addr = AW'(cy_q) * AW'(GRID_WIDTH) + AW'(cx_q);
	assign sum  = 18'($signed(rdata)) + 18'(inc_q);
	always_comb begin
		if (sum > 18'sd32767) begin
			sat_val = 16'sd32767;
		end else if (sum < -18'sd32768) begin
			sat_val = -16'sd32768;
		end else begin
			sat_val = 16'(sum);
		end
	end
	assign we    = (state_q == S_CLEAR) || (state_q == S_WR);
	assign waddr = (state_q == S_CLEAR) ? clr_q : addr;
	assign wdata = (state_q == S_CLEAR) ? 16'd0 : sat_val;
	assign more  = (length_q < LW'(max_range_q)) && (steps_q < 6'(MAX_STEPS));

	ocg_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_WR);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE:  if (start) state_q <= S_RED;
				S_RED:   if (cor_start) state_q <= S_COR;
				S_COR:   if (cor_done) state_q <= S_M0;
				S_M0:    state_q <= S_M1;
				S_M1:    state_q <= S_M2;
				S_M2:    state_q <= S_M3;
				S_M3:    state_q <= S_SQ;
				S_SQ:    if (sq_done) state_q <= S_LO;
				S_LO:    state_q <= S_HI;
				S_HI:    state_q <= S_ROBOT;
				S_ROBOT: state_q <= S_RD;
				S_RD:    state_q <= S_WR;
				S_WR:    state_q <= more ? S_STEP : S_IDLE;
				S_STEP:  state_q <= S_CELL;
				S_CELL:  state_q <= S_EX;
				S_EX:    state_q <= S_EY;
				S_EY:    state_q <= S_R2;
				S_R2:    state_q <= S_RD;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers loaded under the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				beam_q <= beam;
				t_q    <= 18'(beam.robot_heading) + 18'(beam.beam_angle);
			end
			S_RED: begin
				if (t_q < 0) begin
					t_q <= t_q + 18'(DEG360);
				end else if (t_q >= 18'(DEG360)) begin
					t_q <= t_q - 18'(DEG360);
				end
				neg_q <= fold;
			end
			S_COR: c_q <= neg_q ? -cos_val : cos_val;
			S_M1:  dx_q <= 17'((mul_q + (2*MW)'(32768)) >>> 16);
			S_M2:  acc_q <= mul_q;
			S_SQ: begin
				dy_q <= (t_q > 18'(DEG180)) ? -17'(root) : 17'(root);
				lo_q <= 18'(lo_c);
			end
			S_HI:  lo2_q <= mul_q;
			S_ROBOT: begin
				hi2_q    <= mul_q;
				cx_q     <= CW'(ncx);
				cy_q     <= RW'(ncy);
				inc_q    <= 17'(free_q) + 17'(prior_q);
				px_q     <= PW'(beam_q.robot_x);
				py_q     <= PW'(beam_q.robot_y);
				length_q <= LW'(step_q);
				steps_q  <= '0;
			end
			S_WR: begin
				res_q.cell_x     <= 6'(cx_q);
				res_q.cell_y     <= 6'(cy_q);
				res_q.cell_value <= sat_val;
				res_q.last       <= !more;
			end
			S_STEP: begin
				px_q     <= px_q + PW'(dx_q);
				py_q     <= py_q + PW'(dy_q);
				length_q <= length_q + LW'(step_q);
				steps_q  <= steps_q + 6'd1;
			end
			S_CELL: begin
				same_q <= (CW'(ncx) == cx_q) && (RW'(ncy) == cy_q);
				cx_q   <= CW'(ncx);
				cy_q   <= RW'(ncy);
			end
			S_EY:  acc_q <= mul_q;
			S_R2:  inc_q <= inc_c;
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire
